[hdl/sclm_pkg.sv]
// Package for the slot cache LRU manager: sizes, slot states, operation codes,
// controller states and the cell command struct. No dependencies.
`timescale 1ns / 1ps
package sclm_pkg;

   localparam int unsigned RING_SLOTS = 16;
   localparam int unsigned SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(RING_SLOTS + 1);
   localparam int unsigned KEY_W = 16;
   localparam int unsigned REFS_W = 8;
   localparam int unsigned TICK_W = 64;
   localparam int unsigned IDX_W = 4;

   typedef enum logic [1:0] {
      ST_EMPTY    = 2'd0,
      ST_LOADING  = 2'd1,
      ST_READY    = 2'd2,
      ST_CONSUMED = 2'd3
   } slot_state_type;

   typedef enum logic [2:0] {
      OP_PREFETCH   = 3'd0,
      OP_LOAD_DONE  = 3'd1,
      OP_CLAIM_ANY  = 3'd2,
      OP_CLAIM_KEY  = 3'd3,
      OP_RELEASE    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CT_IDLE,
      CT_SCAN,
      CT_APPLY,
      CT_RESP
   } ctl_state_type;

   // Action applied by one cell at the end of an operation.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_ALLOC,
      ACT_HIT,
      ACT_LOAD_DONE,
      ACT_CLAIM_ANY,
      ACT_CLAIM_KEY,
      ACT_RELEASE
   } act_type;

   // Command broadcast from the controller to the cells.
   typedef struct packed {
      logic                  scan_shift;
      logic                  apply;
      act_type               act;
      logic [SLOT_W-1:0]     target;
      logic [KEY_W-1:0]      layer;
      logic [KEY_W-1:0]      expert;
      logic                  load_ok;
      logic [TICK_W-1:0]     tick;
   } cell_cmd_type;

   // Per-slot summary handed along the chain during a scan.
   typedef struct packed {
      slot_state_type        status;
      logic                  key_eq;
      logic [REFS_W-1:0]     refs;
      logic                  filled;
      logic [TICK_W-1:0]     last_use;
      logic [SLOT_W-1:0]     index;
   } slot_view_type;

endpackage

[hdl/slot_cache_lru_manager.sv]
// Top level of the slot cache LRU manager: a ring of slot cells and the
// request sequencer. Depends on sclm_pkg, sclm_cell and sclm_ctrl.
//
// Usage:
// A request transfer on the req_ channel carries one operation (prefetch,
// load done, claim any ready, claim by key, release). Each request yields
// exactly one response transfer on the rsp_ channel.
// The block handles one request at a time. After a request is accepted, the
// slot views rotate through the cell ring to the sequencer, one slot per
// cycle, so a scan visits all RING_SLOTS slots. The apply state then selects
// the slot and updates its cell, and the response is presented the cycle
// after that. A new request is taken the cycle after the response transfer;
// the scan over the ring sets the time that each request takes.
// While rsp_stall is high the response holds steady and req_stall stays
// high. Reset empties every slot, clears reference counts, ticks and the
// use counter, and leaves the block idle with no response pending.
`timescale 1ns / 1ps
module slot_cache_lru_manager (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [15:0] req_layer_id,
   input  logic [15:0] req_expert_id,
   input  logic        req_speculative,
   input  logic [3:0]  req_slot_index,
   input  logic        req_load_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_success,
   output logic [3:0]  rsp_result_slot,
   output logic        rsp_issue_load,
   output logic        rsp_load_priority,
   output logic [15:0] rsp_load_layer,
   output logic [15:0] rsp_load_expert
);

   sclm_pkg::cell_cmd_type  cmd;
   sclm_pkg::slot_view_type views [sclm_pkg::RING_SLOTS];

   // Cell i hands its view to cell i-1; cell 0 feeds the sequencer and the
   // ring closes back to the last cell.
   for (genvar g = 0; g < sclm_pkg::RING_SLOTS; g++) begin : g_cell
      sclm_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .my_index       (sclm_pkg::SLOT_W'(g)),
         .cmd            (cmd),
         .view_from_next (views[(g + 1) % sclm_pkg::RING_SLOTS]),
         .view_out       (views[g])
      );
   end

   sclm_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_layer_id      (req_layer_id),
      .req_expert_id     (req_expert_id),
      .req_speculative   (req_speculative),
      .req_slot_index    (req_slot_index),
      .req_load_ok       (req_load_ok),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_success       (rsp_success),
      .rsp_result_slot   (rsp_result_slot),
      .rsp_issue_load    (rsp_issue_load),
      .rsp_load_priority (rsp_load_priority),
      .rsp_load_layer    (rsp_load_layer),
      .rsp_load_expert   (rsp_load_expert),
      .head_view         (views[0]),
      .cmd               (cmd)
   );

   // The block never takes a request while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken with response pending");

   // A load request always comes with success.
   a_issue_success: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_issue_load) |-> rsp_success)
      else $error("load issued without success");

   // A request transfer never yields a response in the next cycle.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid) else $error("response too early");

endmodule

[hdl/sclm_cell.sv]
// One slot of the cache: holds its status, key, reference count and tick,
// and forms a shift chain that rotates its view toward the controller.
// Depends on sclm_pkg.
`timescale 1ns / 1ps
module sclm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sclm_pkg::SLOT_W-1:0]   my_index,
   input  sclm_pkg::cell_cmd_type        cmd,
   input  sclm_pkg::slot_view_type       view_from_next,
   output sclm_pkg::slot_view_type       view_out
);

   sclm_pkg::slot_state_type               status_ff, status_in;
   logic [sclm_pkg::KEY_W-1:0]             layer_ff, layer_in;
   logic [sclm_pkg::KEY_W-1:0]             expert_ff, expert_in;
   logic [sclm_pkg::REFS_W-1:0]            refs_ff, refs_in;
   logic [sclm_pkg::TICK_W-1:0]            last_ff, last_in;
   logic                                   filled_ff, filled_in;
   sclm_pkg::slot_view_type                view_ff, view_in;
   logic                                   sel;

   assign sel = cmd.apply && (cmd.target == my_index);

   always_comb begin
      status_in = status_ff;
      layer_in  = layer_ff;
      expert_in = expert_ff;
      refs_in   = refs_ff;
      last_in   = last_ff;
      filled_in = filled_ff;
      if (sel) begin
         case (cmd.act)
            sclm_pkg::ACT_ALLOC: begin
               status_in = sclm_pkg::ST_LOADING;
               layer_in  = cmd.layer;
               expert_in = cmd.expert;
               refs_in   = '0;
               filled_in = 1'b0;
               last_in   = cmd.tick;
            end
            sclm_pkg::ACT_HIT: last_in = cmd.tick;
            sclm_pkg::ACT_LOAD_DONE: begin
               status_in = cmd.load_ok ? sclm_pkg::ST_READY : sclm_pkg::ST_EMPTY;
               if (cmd.load_ok) begin
                  filled_in = 1'b1;
               end
            end
            sclm_pkg::ACT_CLAIM_ANY: begin
               status_in = sclm_pkg::ST_CONSUMED;
               last_in   = cmd.tick;
            end
            sclm_pkg::ACT_CLAIM_KEY: begin
               status_in = sclm_pkg::ST_CONSUMED;
               if (refs_ff != '1) begin
                  refs_in = refs_ff + 1'b1;
               end
               last_in = cmd.tick;
            end
            sclm_pkg::ACT_RELEASE: begin
               if (refs_ff != '0) begin
                  refs_in = refs_ff - 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // The view register loads from its own slot at the start of a scan and
   // then passes the neighbor's view down the chain one step per cycle.
   always_comb begin
      if (cmd.scan_shift) begin
         view_in = view_from_next;
      end else begin
         view_in.status   = status_in;
         view_in.key_eq   = (layer_in == cmd.layer) && (expert_in == cmd.expert);
         view_in.refs     = refs_in;
         view_in.filled   = filled_in;
         view_in.last_use = last_in;
         view_in.index    = my_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= sclm_pkg::ST_EMPTY;
         layer_ff  <= '0;
         expert_ff <= '0;
         refs_ff   <= '0;
         last_ff   <= '0;
         filled_ff <= 1'b0;
      end else begin
         status_ff <= status_in;
         layer_ff  <= layer_in;
         expert_ff <= expert_in;
         refs_ff   <= refs_in;
         last_ff   <= last_in;
         filled_ff <= filled_in;
      end
      view_ff <= view_in;
   end

   assign view_out = view_ff;

endmodule

[hdl/sclm_ctrl.sv]
// Sequencer of the slot cache: takes one request, watches the slot views
// arrive from the cell chain, picks the slot and commands the update.
// Depends on sclm_pkg.
`timescale 1ns / 1ps
module sclm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_operation,
   input  logic [15:0]                   req_layer_id,
   input  logic [15:0]                   req_expert_id,
   input  logic                          req_speculative,
   input  logic [3:0]                    req_slot_index,
   input  logic                          req_load_ok,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_success,
   output logic [3:0]                    rsp_result_slot,
   output logic                          rsp_issue_load,
   output logic                          rsp_load_priority,
   output logic [15:0]                   rsp_load_layer,
   output logic [15:0]                   rsp_load_expert,
   input  sclm_pkg::slot_view_type       head_view,
   output sclm_pkg::cell_cmd_type        cmd
);

   sclm_pkg::ctl_state_type    state_ff, state_in;
   logic [2:0]                 op_ff, op_in;
   logic [15:0]                layer_ff, layer_in, expert_ff, expert_in;
   logic                       spec_ff, spec_in, ok_ff, ok_in;
   logic [3:0]                 idx_ff, idx_in;
   logic [sclm_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       hit_ff, hit_in, free_ff, free_in, old_ff, old_in;
   logic [sclm_pkg::SLOT_W-1:0] hit_s_ff, hit_s_in, free_s_ff, free_s_in, old_s_ff, old_s_in;
   logic [sclm_pkg::TICK_W-1:0] best_ff, best_in, tick_ff, tick_in;
   logic                       succ_ff, succ_in, iss_ff, iss_in;
   logic [sclm_pkg::SLOT_W-1:0] slot_ff, slot_in;
   sclm_pkg::act_type          act_ff, act_in;
   logic                       idx_ok;
   sclm_pkg::slot_view_type    v;
   logic                       claim_key_ok;

   assign v = head_view;
   assign idx_ok = ({{(32-sclm_pkg::IDX_W){1'b0}}, idx_ff} < sclm_pkg::RING_SLOTS);
   assign claim_key_ok = v.key_eq && ((v.status == sclm_pkg::ST_READY) ||
      ((v.status == sclm_pkg::ST_CONSUMED) && (v.refs == '0) && v.filled));

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; layer_in = layer_ff; expert_in = expert_ff;
      spec_in = spec_ff; ok_in = ok_ff; idx_in = idx_ff;
      cnt_in = cnt_ff;
      hit_in = hit_ff; free_in = free_ff; old_in = old_ff;
      hit_s_in = hit_s_ff; free_s_in = free_s_ff; old_s_in = old_s_ff;
      best_in = best_ff; tick_in = tick_ff;
      succ_in = succ_ff; iss_in = iss_ff; slot_in = slot_ff; act_in = act_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd.scan_shift = 1'b0;
      cmd.apply = 1'b0;
      cmd.act = act_ff;
      cmd.target = slot_ff;
      cmd.layer = layer_ff;
      cmd.expert = expert_ff;
      cmd.load_ok = ok_ff;
      cmd.tick = tick_ff;
      case (state_ff)
         sclm_pkg::CT_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in = req_operation; layer_in = req_layer_id;
               expert_in = req_expert_id; spec_in = req_speculative;
               idx_in = req_slot_index; ok_in = req_load_ok;
               cnt_in = '0;
               hit_in = 1'b0; free_in = 1'b0; old_in = 1'b0;
               cmd.layer = req_layer_id;
               cmd.expert = req_expert_id;
               state_in = sclm_pkg::CT_SCAN;
            end
         end
         sclm_pkg::CT_SCAN: begin
            // Views arrive in index order, one per cycle.
            cmd.scan_shift = 1'b1;
            case (op_ff)
               sclm_pkg::OP_PREFETCH: begin
                  if (!hit_ff && v.status != sclm_pkg::ST_EMPTY && v.key_eq) begin
                     hit_in = 1'b1; hit_s_in = v.index;
                  end
                  if (!free_ff && v.status == sclm_pkg::ST_EMPTY) begin
                     free_in = 1'b1; free_s_in = v.index;
                  end
                  if ((v.status == sclm_pkg::ST_READY || v.status == sclm_pkg::ST_CONSUMED)
                      && v.refs == '0 && (!old_ff || v.last_use < best_ff)) begin
                     old_in = 1'b1; old_s_in = v.index; best_in = v.last_use;
                  end
               end
               sclm_pkg::OP_CLAIM_ANY: begin
                  if (!hit_ff && v.status == sclm_pkg::ST_READY) begin
                     hit_in = 1'b1; hit_s_in = v.index;
                  end
               end
               sclm_pkg::OP_CLAIM_KEY: begin
                  if (!hit_ff && claim_key_ok) begin
                     hit_in = 1'b1; hit_s_in = v.index;
                  end
               end
               sclm_pkg::OP_LOAD_DONE: begin
                  if (idx_ok && v.index == idx_ff[sclm_pkg::SLOT_W-1:0]
                      && v.status == sclm_pkg::ST_LOADING) begin
                     hit_in = 1'b1; hit_s_in = v.index;
                  end
               end
               default: ;
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sclm_pkg::CNT_W'(sclm_pkg::RING_SLOTS - 1)) begin
               state_in = sclm_pkg::CT_APPLY;
            end
         end
         sclm_pkg::CT_APPLY: begin
            succ_in = 1'b0; iss_in = 1'b0; act_in = sclm_pkg::ACT_NONE;
            slot_in = '0;
            case (op_ff)
               sclm_pkg::OP_PREFETCH: begin
                  if (hit_ff) begin
                     succ_in = 1'b1; slot_in = hit_s_ff; act_in = sclm_pkg::ACT_HIT;
                  end else if (free_ff || old_ff) begin
                     succ_in = 1'b1; iss_in = 1'b1;
                     slot_in = free_ff ? free_s_ff : old_s_ff;
                     act_in = sclm_pkg::ACT_ALLOC;
                  end
               end
               sclm_pkg::OP_LOAD_DONE: if (hit_ff) begin
                  succ_in = 1'b1; slot_in = hit_s_ff; act_in = sclm_pkg::ACT_LOAD_DONE;
               end
               sclm_pkg::OP_CLAIM_ANY: if (hit_ff) begin
                  succ_in = 1'b1; slot_in = hit_s_ff; act_in = sclm_pkg::ACT_CLAIM_ANY;
               end
               sclm_pkg::OP_CLAIM_KEY: if (hit_ff) begin
                  succ_in = 1'b1; slot_in = hit_s_ff; act_in = sclm_pkg::ACT_CLAIM_KEY;
               end
               sclm_pkg::OP_RELEASE: if (idx_ok) begin
                  succ_in = 1'b1; slot_in = idx_ff[sclm_pkg::SLOT_W-1:0];
                  act_in = sclm_pkg::ACT_RELEASE;
               end
               default: ;
            endcase
            cmd.apply = 1'b1;
            cmd.act = act_in;
            cmd.target = slot_in;
            if (act_in == sclm_pkg::ACT_HIT || act_in == sclm_pkg::ACT_ALLOC ||
                act_in == sclm_pkg::ACT_CLAIM_ANY || act_in == sclm_pkg::ACT_CLAIM_KEY) begin
               tick_in = tick_ff + 1'b1;
            end
            state_in = sclm_pkg::CT_RESP;
         end
         sclm_pkg::CT_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = sclm_pkg::CT_IDLE;
            end
         end
         default: state_in = sclm_pkg::CT_IDLE;
      endcase
   end

   assign rsp_success       = succ_ff;
   assign rsp_result_slot   = 4'(slot_ff);
   assign rsp_issue_load    = iss_ff;
   assign rsp_load_priority = iss_ff & spec_ff;
   assign rsp_load_layer    = iss_ff ? layer_ff : '0;
   assign rsp_load_expert   = iss_ff ? expert_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sclm_pkg::CT_IDLE;
         tick_ff  <= '0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
      end
      op_ff <= op_in; layer_ff <= layer_in; expert_ff <= expert_in;
      spec_ff <= spec_in; ok_ff <= ok_in; idx_ff <= idx_in; cnt_ff <= cnt_in;
      hit_ff <= hit_in; free_ff <= free_in; old_ff <= old_in;
      hit_s_ff <= hit_s_in; free_s_ff <= free_s_in; old_s_ff <= old_s_in;
      best_ff <= best_in; succ_ff <= succ_in; iss_ff <= iss_in;
      slot_ff <= slot_in; act_ff <= act_in;
   end

endmodule
